// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros for the biquad block
// included by files that carry concurrent checks; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   `ASSERT_HOLDS(label, clk, rst, !(expr), msg)

`endif

// ===== hw/rtl/petbq_pkg.sv =====
// shared types, widths and register codes for the per-element biquad
// no dependencies; imported by every module of the block but petbq_ram
package petbq_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int INDEX_BITS     = 16;
   localparam int COEF_BITS      = 18;
   localparam int COEF_FRAC      = 14;
   localparam int HIST_FRAC      = 8;
   localparam int HIST_BITS      = SAMPLE_BITS + HIST_FRAC;
   localparam int FRAME_ELEMENTS = 65536;
   localparam int ADDR_BITS      = (FRAME_ELEMENTS > 1) ? $clog2(FRAME_ELEMENTS) : 1;
   localparam int NUM_REGS       = 5;
   localparam int CSR_INDEX_BITS = 3;

   // datapath widths
   localparam int PROD_X_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int PROD_Y_BITS = COEF_BITS + HIST_BITS;
   localparam int FF_BITS     = PROD_X_BITS + 2;
   localparam int FB_BITS     = PROD_Y_BITS + 1;
   localparam int ACC_BITS    = FF_BITS + HIST_FRAC + 2;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1 << COEF_FRAC);
   localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_B0 = '0,
      REG_B1,
      REG_B2,
      REG_A1,
      REG_A2
   } csr_reg_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
   } coef_set_type;

   // one element's history entry
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x1;
      logic signed [SAMPLE_BITS-1:0] x2;
      logic signed [HIST_BITS-1:0]   y1;
      logic signed [HIST_BITS-1:0]   y2;
   } hist_type;

   localparam int STATE_BITS = $bits(hist_type);

   // fields carried down the pipe for write-back
   typedef struct packed {
      logic [INDEX_BITS-1:0]         index;
      logic signed [SAMPLE_BITS-1:0] x;
      logic signed [SAMPLE_BITS-1:0] x1;
      logic signed [HIST_BITS-1:0]   y1;
   } carry_type;

   typedef struct packed {
      carry_type                  carry;
      logic signed [ACC_BITS-1:0] acc;
   } acc_stage_type;

   typedef struct packed {
      logic signed [HIST_BITS-1:0]   ynew;
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic                          clipped;
   } round_out_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } pipe_en_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] s2;
      logic [INDEX_BITS-1:0] s3;
   } inflight_type;

   function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [INDEX_BITS-1:0] index);
      return ADDR_BITS'(index % FRAME_ELEMENTS);
   endfunction

endpackage

// ===== hw/rtl/petbq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module petbq_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/petbq_mac.sv =====
// multiply and accumulate stages of the biquad: products, partial sums, final sum
// depends on petbq_pkg
module petbq_mac (
   input  logic                     clock,
   input  petbq_pkg::pipe_en_type   en,
   input  petbq_pkg::carry_type     in_carry,
   input  petbq_pkg::hist_type      hist,
   input  petbq_pkg::coef_set_type  coefs,
   output petbq_pkg::acc_stage_type stage4,
   output petbq_pkg::inflight_type  inflight
);
   import petbq_pkg::*;

   // stage 2: products
   carry_type                     c2_ff, c2_in;
   logic signed [PROD_X_BITS-1:0] p0_ff, p1_ff, p2_ff, p0_in, p1_in, p2_in;
   logic signed [PROD_Y_BITS-1:0] p3_ff, p4_ff, p3_in, p4_in;
   // stage 3: partial sums
   carry_type                     c3_ff, c3_in;
   logic signed [FF_BITS-1:0]     ff_ff, ff_in;
   logic signed [FB_BITS-1:0]     fb_ff, fb_in;
   // stage 4: accumulator
   carry_type                     c4_ff, c4_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;

   always_comb begin
      c2_in = in_carry;
      p0_in = coefs.b0 * in_carry.x;
      p1_in = coefs.b1 * hist.x1;
      p2_in = coefs.b2 * hist.x2;
      p3_in = coefs.a1 * hist.y1;
      p4_in = coefs.a2 * hist.y2;
   end

   always_comb begin
      c3_in = c2_ff;
      ff_in = FF_BITS'(p0_ff) + FF_BITS'(p1_ff) + FF_BITS'(p2_ff);
      fb_in = FB_BITS'(p3_ff) + FB_BITS'(p4_ff);
   end

   always_comb begin
      c4_in  = c3_ff;
      acc_in = (ACC_BITS'(ff_ff) <<< HIST_FRAC) - ACC_BITS'(fb_ff);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         c2_ff <= c2_in;
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         p4_ff <= p4_in;
      end
      if (en.s3) begin
         c3_ff <= c3_in;
         ff_ff <= ff_in;
         fb_ff <= fb_in;
      end
      if (en.s4) begin
         c4_ff  <= c4_in;
         acc_ff <= acc_in;
      end
   end

   assign stage4.carry = c4_ff;
   assign stage4.acc   = acc_ff;
   assign inflight.s2  = c2_ff.index;
   assign inflight.s3  = c3_ff.index;

endmodule

// ===== hw/rtl/petbq_round.sv =====
// rounding and saturation of the accumulator to stored history and sample result
// depends on petbq_pkg
module petbq_round (
   input  petbq_pkg::acc_stage_type stage,
   output petbq_pkg::round_out_type result
);
   import petbq_pkg::*;

   localparam int YW = ACC_BITS - COEF_FRAC;
   localparam logic signed [YW-1:0] Y_MAX = YW'((1 << (HIST_BITS - 1)) - 1);
   localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;
   localparam logic signed [HIST_BITS-1:0]   HIST_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
   localparam logic signed [HIST_BITS-1:0]   HIST_MIN = ~HIST_MAX;
   localparam logic signed [SAMPLE_BITS-1:0] RES_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] RES_MIN  = ~RES_MAX;
   localparam logic signed [ACC_BITS-1:0]    HALF_Y   = ACC_BITS'(1 << (COEF_FRAC - 1));
   localparam logic [HIST_BITS:0]            HALF_R   = (HIST_BITS+1)'(1 << (HIST_FRAC - 1));

   logic signed [ACC_BITS-1:0]    acc_rnd;
   logic signed [YW-1:0]          y_full;
   logic                          y_hi, y_lo;
   logic signed [HIST_BITS-1:0]   y_sat;
   logic [HIST_BITS:0]            r_sum;
   logic [SAMPLE_BITS:0]          r_full;
   logic                          r_clip;
   logic signed [SAMPLE_BITS-1:0] r_sat;

   always_comb begin
      // half-up rounding to 8 fraction bits, then clamp to history width
      acc_rnd = stage.acc + HALF_Y;
      y_full  = YW'(acc_rnd >>> COEF_FRAC);
      y_hi    = y_full > Y_MAX;
      y_lo    = y_full < Y_MIN;
      if (y_hi) begin
         y_sat = HIST_MAX;
      end else if (y_lo) begin
         y_sat = HIST_MIN;
      end else begin
         y_sat = HIST_BITS'(y_full);
      end
      // half-up rounding to integer, then clamp to sample width
      r_sum  = {y_sat[HIST_BITS-1], y_sat} + HALF_R;
      r_full = r_sum[HIST_BITS:HIST_FRAC];
      r_clip = r_full[SAMPLE_BITS] != r_full[SAMPLE_BITS-1];
      if (r_clip) begin
         r_sat = r_full[SAMPLE_BITS] ? RES_MIN : RES_MAX;
      end else begin
         r_sat = r_full[SAMPLE_BITS-1:0];
      end
   end

   assign result.ynew     = y_sat;
   assign result.filtered = r_sat;
   assign result.clipped  = y_hi | y_lo | r_clip;

endmodule

// ===== hw/rtl/per_element_temporal_biquad.sv =====
// per-element temporal biquad: top level with history store, pipeline control
// depends on petbq_pkg, petbq_ram, petbq_mac, petbq_round and assert_macros.svh
//
// usage
//   req channel: one transfer per frame element, tdata = {sample, element_index}.
//   rsp channel: one transfer per request in the same order,
//     tdata = {filtered, element_out}, tuser = clipped.
//   csr channel: coefficient writes, csr_index selects b0, b1, b2, a1, a2
//     (indexes 0..4); other indexes are dropped. always ready; write only
//     while the block is idle.
// pipeline: a request passes history read, multiply, partial sums, final sum
//   and rounding into the output register, in that order.
// throughput: one element per cycle while rsp_tready is high. a request whose
//   element is still in one of the four stages before write-back is held off
//   until that write lands.
// reset: coefficients go to b0 = 1.0 and the rest zero; then a clearing pass
//   zeroes all 65536 entries of the history store, one entry a cycle, with
//   req_tready low throughout.
// stall: when rsp_tready is low the output register holds, bubbles in the pipe
//   are squeezed out and new requests keep flowing until every stage is full.
`include "assert_macros.svh"

module per_element_temporal_biquad (
   input  logic        clock,
   input  logic        reset,
   // request: [15:0] element_index, [31:16] sample
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // result: [15:0] element_out, [31:16] filtered
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // result flag: [0] clipped
   output logic [0:0]  rsp_tuser,
   // coefficient writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [petbq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [petbq_pkg::COEF_BITS-1:0]      csr_data
);
   import petbq_pkg::*;

   // coefficient registers
   coef_set_type coef_ff, coef_in;

   // clearing pass
   logic                 clear_ff, clear_in;
   logic [ADDR_BITS-1:0] clear_addr_ff, clear_addr_in;

   // stage valid bits and stage 1 payload
   logic v1_ff, v2_ff, v3_ff, v4_ff, out_v_ff;
   logic v1_in, v2_in, v3_in, v4_in, out_v_in;
   logic [INDEX_BITS-1:0]         idx1_ff;
   logic signed [SAMPLE_BITS-1:0] x1s_ff;

   // output register payload
   logic [INDEX_BITS-1:0]         out_idx_ff;
   logic signed [SAMPLE_BITS-1:0] out_filt_ff;
   logic                          out_clip_ff;

   // handshake and hazard
   logic                  rdy1, rdy2, rdy3, rdy4, rdy_out;
   logic                  req_fire;
   logic                  hazard;
   logic [INDEX_BITS-1:0] req_index;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic [ADDR_BITS-1:0]  req_addr;

   // store ports
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   hist_type              wr_entry;
   logic [STATE_BITS-1:0] rd_data;
   hist_type              hist_rd;

   carry_type     carry1;
   pipe_en_type   pipe_en;
   acc_stage_type stage4;
   inflight_type  inflight;
   round_out_type rounded;

   assign req_index  = req_tdata[INDEX_BITS-1:0];
   assign req_sample = req_tdata[INDEX_BITS +: SAMPLE_BITS];
   assign req_addr   = elem_addr(req_index);

   // ready chain: a stage takes new data when it is empty or moving on
   assign rdy_out = !out_v_ff || rsp_tready;
   assign rdy4    = !v4_ff || rdy_out;
   assign rdy3    = !v3_ff || rdy4;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;

   // same element still ahead of write-back: its history is not in the store yet
   assign hazard = (v1_ff && (elem_addr(idx1_ff) == req_addr))
                || (v2_ff && (elem_addr(inflight.s2) == req_addr))
                || (v3_ff && (elem_addr(inflight.s3) == req_addr))
                || (v4_ff && (elem_addr(stage4.carry.index) == req_addr));

   assign req_tready = rdy1 && !hazard && !clear_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // coefficient writes
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_B0:  coef_in.b0 = csr_data;
            REG_B1:  coef_in.b1 = csr_data;
            REG_B2:  coef_in.b2 = csr_data;
            REG_A1:  coef_in.a1 = csr_data;
            REG_A2:  coef_in.a2 = csr_data;
            default: coef_in = coef_ff;
         endcase
      end
   end

   // clearing pass after reset
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_BITS'(FRAME_ELEMENTS - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   // valid bits follow the ready chain
   always_comb begin
      v1_in    = rdy1    ? req_fire : v1_ff;
      v2_in    = rdy2    ? v1_ff    : v2_ff;
      v3_in    = rdy3    ? v2_ff    : v3_ff;
      v4_in    = rdy4    ? v3_ff    : v4_ff;
      out_v_in = rdy_out ? v4_ff    : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff       <= '{b0: COEF_ONE, b1: COEF_ZERO, b2: COEF_ZERO,
                            a1: COEF_ZERO, a2: COEF_ZERO};
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         coef_ff       <= coef_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
         v4_ff         <= v4_in;
         out_v_ff      <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rdy1) begin
         idx1_ff <= req_index;
         x1s_ff  <= req_sample;
      end
      if (rdy_out) begin
         out_idx_ff  <= stage4.carry.index;
         out_filt_ff <= rounded.filtered;
         out_clip_ff <= rounded.clipped;
      end
   end

   // history store: read as the request enters stage 1, written as the
   // element leaves stage 4 for the output register
   assign wr_en   = clear_ff || (v4_ff && rdy_out);
   assign wr_addr = clear_ff ? clear_addr_ff : elem_addr(stage4.carry.index);

   always_comb begin
      if (clear_ff) begin
         wr_entry = '0;
      end else begin
         wr_entry.x1 = stage4.carry.x;
         wr_entry.x2 = stage4.carry.x1;
         wr_entry.y1 = rounded.ynew;
         wr_entry.y2 = stage4.carry.y1;
      end
   end

   petbq_ram #(
      .WIDTH (STATE_BITS),
      .DEPTH (FRAME_ELEMENTS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rdy1),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   assign hist_rd = hist_type'(rd_data);

   always_comb begin
      carry1.index = idx1_ff;
      carry1.x     = x1s_ff;
      carry1.x1    = hist_rd.x1;
      carry1.y1    = hist_rd.y1;
   end

   assign pipe_en.s2 = rdy2;
   assign pipe_en.s3 = rdy3;
   assign pipe_en.s4 = rdy4;

   petbq_mac u_mac (
      .clock    (clock),
      .en       (pipe_en),
      .in_carry (carry1),
      .hist     (hist_rd),
      .coefs    (coef_ff),
      .stage4   (stage4),
      .inflight (inflight)
   );

   petbq_round u_round (
      .stage  (stage4),
      .result (rounded)
   );

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = {out_filt_ff, out_idx_ff};
   assign rsp_tuser[0] = out_clip_ff;

   // checks
   `ASSERT_NEVER(a_no_req_while_clearing, clock, reset, req_fire && clear_ff,
      "request transfer accepted during clearing pass")
   `ASSERT_NEVER(a_no_rsp_while_clearing, clock, reset, out_v_ff && clear_ff,
      "result presented during clearing pass")
   `ASSERT_NEVER(a_no_read_write_clash, clock, reset,
      req_fire && wr_en && (wr_addr == req_addr),
      "history read and write-back of the same element at one edge")
   `ASSERT_HOLDS(a_clear_runs_full, clock, reset,
      $fell(clear_ff) |-> ($past(clear_addr_ff) == ADDR_BITS'(FRAME_ELEMENTS - 1)),
      "clearing pass ended early")

endmodule
